// File: sv/bounded_dedup_set_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded dedup set table
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEDUP_SET_TABLE_UNIT_MACROS_SVH
`define BOUNDED_DEDUP_SET_TABLE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BDST_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define BDST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BDST_ASSERT_IMPL(label, clk, rst, ante, cons)

`define BDST_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/bdst_pkg.sv
// ----------------------------------------------------------------------------
// bdst_pkg
// Types and constants of the bounded dedup set table.
// ----------------------------------------------------------------------------
`default_nettype none

package bdst_pkg;

  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;
  localparam int TOTAL_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    ST_PRESENT  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_ABSENT   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESP
  } state_t;

endpackage

`default_nettype wire

// File: sv/bounded_dedup_set_table_unit.sv
// ----------------------------------------------------------------------------
// bounded_dedup_set_table_unit
// Set of unique 32-bit values with membership query and insert-if-absent.
// ----------------------------------------------------------------------------
//  channel   ports                               transfer when
//  item      start, busy, mode, value            start && !busy
//  result    done, status, entry_total           done (one cycle)
//  config    cfg_valid, cfg_ready, capacity      cfg_valid && cfg_ready
//
//  While an item is handled busy stays high: one entry memory read per cycle
//  over the stored entries, then a response state to decide and write back.
//  A hit ends the scan early. done pulses in the first cycle with busy low.
//  rst (synchronous) empties the set and sets capacity to 16.
//  Config is taken only while busy is low.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_dedup_set_table_unit_macros.svh"

module bounded_dedup_set_table_unit
  import bdst_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      mode,
  input  wire logic signed [VALUE_W-1:0] value,
  output logic                           done,
  output logic             [1:0]         status,
  output logic             [TOTAL_W-1:0] entry_total,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic        [CAP_W-1:0]   capacity
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LIM_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_ENTRIES);

  state_t             state;
  state_t             state_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [CNT_W-1:0]   idx;
  logic [CAP_W-1:0]   cap;
  logic [VALUE_W-1:0] key;
  logic               op_mode;
  logic               found;
  logic               cmp_valid;
  logic               match;
  logic               issue;
  logic               hit;
  logic               full;
  logic               wr_en;
  logic               resp;
  status_t            status_next;
  logic [LIM_W-1:0]   cap_ext;
  logic [LIM_W-1:0]   lim;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign issue     = (state == S_SCAN) && (idx < count);
  assign hit       = cmp_valid && match;

  assign cap_ext = LIM_W'(cap);
  assign lim     = (cap_ext < MAX_LIM) ? cap_ext : MAX_LIM;
  assign full    = (LIM_W'(count) >= lim);

  bdst_entry_ram #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (key),
    .rd_en   (issue),
    .rd_addr (idx[ADDR_W-1:0]),
    .key     (key),
    .match   (match)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit || !issue) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    resp        = 1'b0;
    wr_en       = 1'b0;
    count_next  = count;
    status_next = ST_ABSENT;
    case (state)
      S_RESP: begin
        resp = 1'b1;
        if (found) begin
          status_next = ST_PRESENT;
        end else if (!op_mode) begin
          status_next = ST_ABSENT;
        end else if (full) begin
          status_next = ST_OVERFLOW;
        end else begin
          status_next = ST_INSERTED;
          wr_en       = 1'b1;
          count_next  = count + CNT_W'(1);
        end
      end
      default: begin
        resp = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap       <= CAP_RESET;
      done      <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      done      <= resp;
      cmp_valid <= issue;
      if (cfg_valid && cfg_ready) begin
        cap <= capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE) begin
      idx <= '0;
    end else if (issue) begin
      idx <= idx + CNT_W'(1);
    end
    if (start && !busy) begin
      key     <= value;
      op_mode <= mode;
    end
    if (state == S_SCAN) begin
      found <= hit;
    end
    if (resp) begin
      status      <= status_next;
      entry_total <= TOTAL_W'(count_next);
    end
  end

  `BDST_ASSERT_NEXT(a_resp_done, clk, rst, state == S_RESP, done && !busy)
  `BDST_ASSERT_IMPL(a_count_max, clk, rst, 1'b1, count <= CNT_W'(MAX_ENTRIES))
  `BDST_ASSERT_IMPL(a_insert_inc, clk, rst, done && status == ST_INSERTED, count == $past(count) + CNT_W'(1))

endmodule

`default_nettype wire

// File: sv/bdst_entry_ram.sv
// ----------------------------------------------------------------------------
// bdst_entry_ram
// Entry store: one write port, one registered read port, key compare.
// ----------------------------------------------------------------------------
`default_nettype none

module bdst_entry_ram
  import bdst_pkg::*;
#(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic               clk,
  input  wire logic               wr_en,
  input  wire logic [ADDR_W-1:0]  wr_addr,
  input  wire logic [VALUE_W-1:0] wr_data,
  input  wire logic               rd_en,
  input  wire logic [ADDR_W-1:0]  rd_addr,
  input  wire logic [VALUE_W-1:0] key,
  output logic                    match
);

  logic [VALUE_W-1:0] mem [DEPTH];
  logic [VALUE_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign match = (rd_data == key);

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the bounded dedup set table
// Drives queries and inserts against a shadow copy of the set that computes
// each status and count. Capacity is changed between phases, including zero
// and values above the table depth. Every result is checked in order.
// ----------------------------------------------------------------------------
module tb_top;
  import bdst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_DEPTH   = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 110;

  localparam logic MODE_QUERY  = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef struct packed {
    logic               op_mode;
    logic [VALUE_W-1:0] op_val;
  } set_req_t;

  typedef struct packed {
    status_t            st;
    logic [TOTAL_W-1:0] total;
  } set_resp_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      mode = MODE_QUERY;
  logic signed [VALUE_W-1:0] value = '0;
  logic                      done;
  logic        [1:0]         status;
  logic        [TOTAL_W-1:0] entry_total;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic        [CAP_W-1:0]   capacity = CAP_RESET;

  // shadow copy of the set
  logic [VALUE_W-1:0] held_vals[SET_DEPTH];
  int                 held_count = 0;
  logic [CAP_W-1:0]   cap_reg = CAP_RESET;

  set_req_t           req_backlog[$];
  set_resp_t          status_due[$];
  logic [VALUE_W-1:0] seen_vals[$];

  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  int gap_left = 0;

  bounded_dedup_set_table_unit #(
    .MAX_ENTRIES(SET_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .value(value),
    .done(done),
    .status(status),
    .entry_total(entry_total),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .capacity(capacity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic apply_set_op(input logic op_mode, input logic [VALUE_W-1:0] op_val);
    set_resp_t r;
    logic      hit;
    int        lim;
    hit = 1'b0;
    for (int i = 0; i < held_count; i++)
      if (held_vals[i] == op_val) hit = 1'b1;
    lim = (cap_reg > SET_DEPTH) ? SET_DEPTH : cap_reg;
    if (hit) begin
      r.st = ST_PRESENT;
    end else if (op_mode == MODE_QUERY) begin
      r.st = ST_ABSENT;
    end else if (held_count >= lim) begin
      r.st = ST_OVERFLOW;
    end else begin
      held_vals[held_count] = op_val;
      held_count++;
      r.st = ST_INSERTED;
    end
    r.total = held_count[TOTAL_W-1:0];
    status_due.push_back(r);
  endtask

  // driver: bursts of items separated by random gaps
  always @(posedge clk) begin : drv
    logic     taken;
    set_req_t req;
    taken = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (taken)
        apply_set_op(mode, value);
      if (!start || taken) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          req = req_backlog.pop_front();
          start <= 1'b1;
          mode <= req.op_mode;
          value <= req.op_val;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : mon
    set_resp_t exp_r;
    if (!rst && done) begin
      if (status_due.size() == 0) begin
        $display("%0t: result with none expected: status=%0d entry_total=%0d",
                 $time, status, entry_total);
        errors++;
      end else begin
        exp_r = status_due.pop_front();
        if (status !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
          errors++;
        end
        if (entry_total !== exp_r.total) begin
          $display("%0t: entry_total expected %0d actual %0d",
                   $time, exp_r.total, entry_total);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_op(input logic op_mode, input logic [VALUE_W-1:0] op_val);
    set_req_t req;
    req.op_mode = op_mode;
    req.op_val = op_val;
    req_backlog.push_back(req);
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    logic [VALUE_W-1:0] v;
    int                 n;
    n = seen_vals.size();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = (n > 0) ? seen_vals[$urandom_range(0, n - 1)] : $urandom;
      4: v = ((n > 0) ? seen_vals[$urandom_range(0, n - 1)] : $urandom)
             ^ (32'd1 << $urandom_range(0, 31));
      5: case ($urandom_range(0, 3))
           0: v = 32'h8000_0000;
           1: v = 32'h7fff_ffff;
           2: v = 32'h0000_0000;
           default: v = 32'hffff_ffff;
         endcase
      6: begin
        v = $urandom_range(0, 7);
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = $urandom;
    endcase
    if (n < 64) seen_vals.push_back(v);
    else if ($urandom_range(0, 3) == 0) seen_vals[$urandom_range(0, n - 1)] = v;
    return v;
  endfunction

  // sampled at negedge so queue updates at the edge have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog.size() != 0 || start || status_due.size() != 0);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    capacity <= cap;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    cap_reg = cap;
  endtask

  initial begin
    logic [CAP_W-1:0] phase_caps[12];
    phase_caps = '{5'd8, 5'd3, 5'd10, 5'd1, 5'd12, 5'd0, 5'd14, 5'd16, 5'd20, 5'd31,
                   5'd0, 5'd0};
    phase_caps[10] = $urandom_range(1, 31);
    phase_caps[11] = $urandom_range(0, 31);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // empty set, extremes, duplicate insert, near-miss query
    queue_op(MODE_QUERY,  32'h8000_0000);
    queue_op(MODE_INSERT, 32'h8000_0000);
    queue_op(MODE_INSERT, 32'h7fff_ffff);
    queue_op(MODE_INSERT, 32'h0000_0000);
    queue_op(MODE_INSERT, 32'hffff_ffff);
    queue_op(MODE_INSERT, 32'h8000_0000);
    queue_op(MODE_QUERY,  32'h7fff_ffff);
    queue_op(MODE_QUERY,  32'h0000_0001);
    queue_op(MODE_QUERY,  32'h7fff_fffe);

    // zero capacity refuses every new insert
    set_capacity(5'd0);
    queue_op(MODE_INSERT, 32'h0000_0005);
    queue_op(MODE_INSERT, 32'h0000_0000);
    queue_op(MODE_QUERY,  32'hffff_ffff);
    queue_op(MODE_QUERY,  32'h0000_0005);

    // capacity below the count: entries kept
    set_capacity(5'd2);
    queue_op(MODE_INSERT, 32'h0000_0007);
    queue_op(MODE_INSERT, 32'h7fff_ffff);
    queue_op(MODE_QUERY,  32'h8000_0000);

    // capacity above the depth
    set_capacity(5'd31);
    queue_op(MODE_INSERT, 32'h0000_0007);
    queue_op(MODE_INSERT, 32'h0000_0008);
    queue_op(MODE_INSERT, 32'h0000_0007);
    queue_op(MODE_QUERY,  32'h0000_0008);

    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p]);
      repeat (PHASE_ITEMS)
        queue_op(logic'($urandom_range(0, 1)), pick_value());
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
